>>> sv/stfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_pkg
// Shared types, codes, constants and the 5x7 font for the text renderer.
// ----------------------------------------------------------------------------
package stfr_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;
    localparam int DEF_TEXT_MAX     = 32;

    localparam int QUEUE_DEPTH = 2;

    // divider widths cover the full parameter ranges
    localparam int DIV_NUM_W = 10;
    localparam int DIV_DEN_W = 9;
    localparam int XO_W      = 11;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [7:0] SPACE_CODE = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [2:0] page;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LAY_SX,
        ST_LAY_SXW,
        ST_LAY_ST,
        ST_LAY_STW,
        ST_LAY_SGL,
        ST_LAY_C0,
        ST_LAY_C0B,
        ST_LAY_C1,
        ST_LAY_C1B,
        ST_RD_CHK,
        ST_RD_D0W,
        ST_RD_F0,
        ST_RD_G0,
        ST_RD_L1,
        ST_RD_D1W,
        ST_RD_F1,
        ST_RD_G1,
        ST_RD_Y,
        ST_RD_YW,
        ST_RD_ROW,
        ST_EMIT
    } back_state_t;

    // column c (0..4) of a glyph, bit 0 is the top row; unknown codes are blank
    function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] c);
        logic [39:0] g;
        logic [7:0]  col;
        g = '0;
        unique case (code)
            8'h30:   g = {8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e};
            8'h31:   g = {8'h00, 8'h42, 8'h7f, 8'h40, 8'h00};
            8'h32:   g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            8'h33:   g = {8'h21, 8'h41, 8'h45, 8'h4b, 8'h31};
            8'h34:   g = {8'h18, 8'h14, 8'h12, 8'h7f, 8'h10};
            8'h35:   g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            8'h36:   g = {8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30};
            8'h37:   g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'h38:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39:   g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1e};
            8'h41:   g = {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
            8'h42:   g = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h43:   g = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h22};
            8'h44:   g = {8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c};
            8'h45:   g = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h41};
            8'h46:   g = {8'h7f, 8'h09, 8'h09, 8'h09, 8'h01};
            8'h49:   g = {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
            8'h4e:   g = {8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f};
            8'h4f:   g = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
            8'h54:   g = {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
            8'h55:   g = {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
            8'h4b:   g = {8'h7f, 8'h08, 8'h14, 8'h22, 8'h41};
            8'h3a:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            8'h2e:   g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            8'h2d:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            default: g = '0;
        endcase
        unique case (c)
            3'd0:    col = g[39:32];
            3'd1:    col = g[31:24];
            3'd2:    col = g[23:16];
            3'd3:    col = g[15:8];
            3'd4:    col = g[7:0];
            default: col = 8'h00;
        endcase
        return col;
    endfunction

endpackage

>>> sv/stfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_if
// Valid/ready channels of the text renderer: command beats in, frame bytes out.
// ----------------------------------------------------------------------------
interface stfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [2:0] page;

    modport source (output valid, output action, output char_code, output column,
                    output page, input ready);
    modport sink   (input valid, input action, input char_code, input column,
                    input page, output ready);
endinterface

interface stfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

>>> sv/stfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_front
// Accepts command beats and decodes the action into a queued operation.
// ----------------------------------------------------------------------------
module stfr_front (
    stfr_req_if.sink        req,
    input  logic            full,
    output logic            push,
    output stfr_pkg::cmd_t  cmd
);

    logic known;

    always_comb
    begin
        known  = 1'b1;
        cmd.op = stfr_pkg::OP_READ;
        unique case (req.action)
            stfr_pkg::ACT_CLEAR:  cmd.op = stfr_pkg::OP_CLEAR;
            stfr_pkg::ACT_APPEND: cmd.op = stfr_pkg::OP_APPEND;
            stfr_pkg::ACT_READ:   cmd.op = stfr_pkg::OP_READ;
            default:              known  = 1'b0;
        endcase
        cmd.char_code = req.char_code;
        cmd.column    = req.column;
        cmd.page      = req.page;
    end

    // unused action code is taken and dropped
    assign req.ready = !full;
    assign push      = req.valid && !full && known;

endmodule

>>> sv/stfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_queue
// Short command queue between the decoding front and the sequencer.
// ----------------------------------------------------------------------------
module stfr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stfr_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output stfr_pkg::cmd_t  pop_cmd
);

    localparam int DEPTH = stfr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stfr_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/stfr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stfr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  stfr_pkg::div_req_t  req,
    output stfr_pkg::div_rsp_t  rsp
);

    localparam int NW    = stfr_pkg::DIV_NUM_W;
    localparam int DW    = stfr_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    q_reg, q_next;
    logic [DW-1:0]    r_reg, r_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {r_reg, q_reg[NW-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.num;
            r_next    = '0;
            d_next    = req.den;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

>>> sv/stfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfr_back
// Sequencer: text store, layout of scale and origins, frame byte rendering.
// ----------------------------------------------------------------------------
module stfr_back #(
    parameter int PANEL_WIDTH  = stfr_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = stfr_pkg::DEF_PANEL_HEIGHT,
    parameter int TEXT_MAX     = stfr_pkg::DEF_TEXT_MAX
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  stfr_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output stfr_pkg::div_req_t  div_req,
    input  stfr_pkg::div_rsp_t  div_rsp,
    stfr_rsp_if.source          rsp
);

    localparam int LEN_W  = $clog2(TEXT_MAX + 1);
    localparam int ADDR_W = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
    localparam int NW     = stfr_pkg::DIV_NUM_W;
    localparam int DW     = stfr_pkg::DIV_DEN_W;
    localparam int XW     = stfr_pkg::XO_W;
    localparam int SY     = PANEL_HEIGHT / 8;
    localparam int SY2    = PANEL_HEIGHT / 16;

    function automatic logic [DW-1:0] cell_span(input logic [LEN_W-1:0] n);
        logic [DW-1:0] nd;
        nd = DW'(n);
        return (nd << 2) + (nd << 1) - DW'(1);
    endfunction

    stfr_pkg::back_state_t state_reg, state_next;
    stfr_pkg::cmd_t        cmd_reg, cmd_next;

    logic [LEN_W-1:0]     length_reg, length_next;
    logic [LEN_W-1:0]     fsp_reg, fsp_next;
    logic                 fsp_valid_reg, fsp_valid_next;
    logic [4:0]           scale_reg, scale_next;
    logic                 stacked_reg, stacked_next;
    logic signed [XW-1:0] xo0_reg, xo0_next;
    logic signed [XW-1:0] xo1_reg, xo1_next;
    logic [7:0]           yo_reg, yo_next;
    logic [4:0]           single_reg, single_next;
    logic [13:0]          prod_reg, prod_next;
    logic [7:0]           glyph0_reg, glyph0_next;
    logic [7:0]           glyph1_reg, glyph1_next;
    logic [2:0]           col_reg, col_next;
    logic                 col_ok_reg, col_ok_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic signed [9:0]    dy_reg, dy_next;
    logic [5:0]           qrow_reg, qrow_next;
    logic [4:0]           rrow_reg, rrow_next;
    logic [2:0]           bit_reg, bit_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;

    logic [7:0]           text_mem [TEXT_MAX];
    logic [7:0]           rd_data_reg;
    logic                 wr_en;

    // layout helpers
    logic [LEN_W-1:0]     b_len;
    logic [LEN_W-1:0]     w_len;
    logic                 stack_ok;
    logic [4:0]           quot_sy;
    logic [4:0]           quot_sy2;
    logic [LEN_W-1:0]     ctr_chars;
    logic signed [14:0]   ctr_v;
    logic signed [14:0]   ctr_half;
    logic [3:0]           yk;
    logic [7:0]           yks;
    logic [7:0]           yo_calc;

    // read helpers
    logic signed [XW:0]   x_ext;
    logic signed [XW:0]   dx0;
    logic signed [XW:0]   dx1;
    logic [17:0]          recip;
    logic [7:0]           idx;
    logic [NW-1:0]        idx_six;
    logic [NW-1:0]        cc;
    logic [LEN_W-1:0]     line_len;
    logic                 line_ok;
    logic [5:0]           y_base;
    logic signed [9:0]    dy0;
    logic                 on_panel;
    logic                 hit;

    assign b_len    = length_reg - fsp_reg - LEN_W'(1);
    assign w_len    = (fsp_reg > b_len) ? fsp_reg : b_len;
    assign stack_ok = fsp_valid_reg && (fsp_reg != '0)
                      && (({1'b0, fsp_reg} + (LEN_W+1)'(1)) < {1'b0, length_reg});
    assign quot_sy  = (div_rsp.quot < NW'(SY))  ? div_rsp.quot[4:0] : 5'(SY);
    assign quot_sy2 = (div_rsp.quot < NW'(SY2)) ? div_rsp.quot[4:0] : 5'(SY2);

    assign ctr_chars = (state_reg == stfr_pkg::ST_LAY_C1) ? b_len
                     : (stacked_reg ? fsp_reg : length_reg);
    assign ctr_v     = $signed({5'b0, 10'(PANEL_WIDTH)}) - $signed({1'b0, prod_reg});
    // halve, rounding toward zero
    assign ctr_half  = $signed(ctr_v + {14'b0, ctr_v[14]}) >>> 1;
    assign yk        = stacked_reg ? 4'd15 : 4'd7;
    assign yks       = {4'b0, yk} * {3'b0, scale_reg};
    assign yo_calc   = (8'(PANEL_HEIGHT) - yks) >> 1;

    assign x_ext   = $signed({5'b0, cmd_reg.column});
    assign dx0     = x_ext - {xo0_reg[XW-1], xo0_reg};
    assign dx1     = x_ext - {xo1_reg[XW-1], xo1_reg};
    // quotient by six through a reciprocal, exact for values below 512
    assign recip   = 18'(div_rsp.quot) * 18'd171;
    assign idx     = recip[17:10];
    assign idx_six = ({2'b0, idx} << 2) + ({2'b0, idx} << 1);
    assign cc      = div_rsp.quot - idx_six;
    assign line_len = (state_reg == stfr_pkg::ST_RD_D1W) ? b_len
                    : (stacked_reg ? fsp_reg : length_reg);
    assign line_ok = (cc < NW'(5)) && (idx < 8'(line_len));

    assign y_base   = {cmd_reg.page, 3'b000};
    assign dy0      = $signed({4'b0, y_base}) - $signed({2'b0, yo_reg});
    assign on_panel = ({3'b0, cmd_reg.page, bit_reg} < 9'(PANEL_HEIGHT));
    assign hit      = on_panel && !dy_reg[9]
                      && (((qrow_reg < 6'd7) && glyph0_reg[qrow_reg[2:0]])
                       || (stacked_reg && (qrow_reg >= 6'd8) && (qrow_reg < 6'd15)
                           && glyph1_reg[qrow_reg[2:0]]));

    assign q_pop          = (state_reg == stfr_pkg::ST_IDLE) && q_valid;
    assign wr_en          = q_pop && (q_cmd.op == stfr_pkg::OP_APPEND)
                            && (length_reg < LEN_W'(TEXT_MAX));
    assign rsp.valid      = out_valid_reg;
    assign rsp.pixel_byte = out_byte_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        length_next    = length_reg;
        fsp_next       = fsp_reg;
        fsp_valid_next = fsp_valid_reg;
        scale_next     = scale_reg;
        stacked_next   = stacked_reg;
        xo0_next       = xo0_reg;
        xo1_next       = xo1_reg;
        yo_next        = yo_reg;
        single_next    = single_reg;
        prod_next      = prod_reg;
        glyph0_next    = glyph0_reg;
        glyph1_next    = glyph1_reg;
        col_next       = col_reg;
        col_ok_next    = col_ok_reg;
        addr_next      = addr_reg;
        dy_next        = dy_reg;
        qrow_next      = qrow_reg;
        rrow_next      = rrow_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_byte_next  = out_byte_reg;
        div_req        = '0;

        unique case (state_reg)
            stfr_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    unique case (q_cmd.op)
                        stfr_pkg::OP_CLEAR:
                        begin
                            length_next    = '0;
                            fsp_next       = '0;
                            fsp_valid_next = 1'b0;
                            scale_next     = '0;
                            stacked_next   = 1'b0;
                            xo0_next       = '0;
                            xo1_next       = '0;
                            yo_next        = '0;
                        end
                        stfr_pkg::OP_APPEND:
                        begin
                            if (wr_en)
                            begin
                                if ((q_cmd.char_code == stfr_pkg::SPACE_CODE) && !fsp_valid_reg)
                                begin
                                    fsp_valid_next = 1'b1;
                                    fsp_next       = length_reg;
                                end
                                length_next = length_reg + LEN_W'(1);
                                state_next  = stfr_pkg::ST_LAY_SX;
                            end
                        end
                        stfr_pkg::OP_READ:
                        begin
                            state_next = stfr_pkg::ST_RD_CHK;
                        end
                        default:
                        begin
                            state_next = stfr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            stfr_pkg::ST_LAY_SX:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(PANEL_WIDTH);
                div_req.den   = cell_span(length_reg);
                state_next    = stfr_pkg::ST_LAY_SXW;
            end

            stfr_pkg::ST_LAY_SXW:
            begin
                if (div_rsp.done)
                begin
                    single_next = quot_sy;
                    state_next  = stack_ok ? stfr_pkg::ST_LAY_ST : stfr_pkg::ST_LAY_SGL;
                end
            end

            stfr_pkg::ST_LAY_ST:
            begin
                div_req.start = 1'b1;
                div_req.num   = NW'(PANEL_WIDTH);
                div_req.den   = cell_span(w_len);
                state_next    = stfr_pkg::ST_LAY_STW;
            end

            stfr_pkg::ST_LAY_STW:
            begin
                if (div_rsp.done)
                begin
                    if (quot_sy2 > single_reg)
                    begin
                        stacked_next = 1'b1;
                        scale_next   = quot_sy2;
                        state_next   = stfr_pkg::ST_LAY_C0;
                    end
                    else
                    begin
                        state_next = stfr_pkg::ST_LAY_SGL;
                    end
                end
            end

            stfr_pkg::ST_LAY_SGL:
            begin
                stacked_next = 1'b0;
                scale_next   = (single_reg == '0) ? 5'd1 : single_reg;
                xo1_next     = '0;
                state_next   = stfr_pkg::ST_LAY_C0;
            end

            stfr_pkg::ST_LAY_C0:
            begin
                prod_next  = {5'b0, cell_span(ctr_chars)} * {9'b0, scale_reg};
                state_next = stfr_pkg::ST_LAY_C0B;
            end

            stfr_pkg::ST_LAY_C0B:
            begin
                xo0_next   = XW'(ctr_half);
                yo_next    = yo_calc;
                state_next = stacked_reg ? stfr_pkg::ST_LAY_C1 : stfr_pkg::ST_IDLE;
            end

            stfr_pkg::ST_LAY_C1:
            begin
                prod_next  = {5'b0, cell_span(ctr_chars)} * {9'b0, scale_reg};
                state_next = stfr_pkg::ST_LAY_C1B;
            end

            stfr_pkg::ST_LAY_C1B:
            begin
                xo1_next   = XW'(ctr_half);
                state_next = stfr_pkg::ST_IDLE;
            end

            stfr_pkg::ST_RD_CHK:
            begin
                glyph0_next = '0;
                glyph1_next = '0;
                if ((length_reg == '0) || ({3'b0, cmd_reg.column} >= 10'(PANEL_WIDTH)))
                begin
                    byte_next  = '0;
                    state_next = stfr_pkg::ST_EMIT;
                end
                else if (!dx0[XW])
                begin
                    div_req.start = 1'b1;
                    div_req.num   = dx0[NW-1:0];
                    div_req.den   = DW'(scale_reg);
                    state_next    = stfr_pkg::ST_RD_D0W;
                end
                else
                begin
                    state_next = stfr_pkg::ST_RD_L1;
                end
            end

            stfr_pkg::ST_RD_D0W:
            begin
                if (div_rsp.done)
                begin
                    col_next    = cc[2:0];
                    col_ok_next = line_ok;
                    addr_next   = ADDR_W'(idx);
                    state_next  = stfr_pkg::ST_RD_F0;
                end
            end

            stfr_pkg::ST_RD_F0:
            begin
                state_next = stfr_pkg::ST_RD_G0;
            end

            stfr_pkg::ST_RD_G0:
            begin
                glyph0_next = col_ok_reg ? stfr_pkg::glyph_column(rd_data_reg, col_reg) : '0;
                state_next  = stfr_pkg::ST_RD_L1;
            end

            stfr_pkg::ST_RD_L1:
            begin
                if (stacked_reg && !dx1[XW])
                begin
                    div_req.start = 1'b1;
                    div_req.num   = dx1[NW-1:0];
                    div_req.den   = DW'(scale_reg);
                    state_next    = stfr_pkg::ST_RD_D1W;
                end
                else
                begin
                    state_next = stfr_pkg::ST_RD_Y;
                end
            end

            stfr_pkg::ST_RD_D1W:
            begin
                if (div_rsp.done)
                begin
                    col_next    = cc[2:0];
                    col_ok_next = line_ok;
                    // second line starts right after the space
                    addr_next   = ADDR_W'(8'(fsp_reg) + 8'd1 + idx);
                    state_next  = stfr_pkg::ST_RD_F1;
                end
            end

            stfr_pkg::ST_RD_F1:
            begin
                state_next = stfr_pkg::ST_RD_G1;
            end

            stfr_pkg::ST_RD_G1:
            begin
                glyph1_next = col_ok_reg ? stfr_pkg::glyph_column(rd_data_reg, col_reg) : '0;
                state_next  = stfr_pkg::ST_RD_Y;
            end

            stfr_pkg::ST_RD_Y:
            begin
                bit_next  = '0;
                byte_next = '0;
                dy_next   = dy0;
                if (!dy0[9])
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'(dy0);
                    div_req.den   = DW'(scale_reg);
                    state_next    = stfr_pkg::ST_RD_YW;
                end
                else
                begin
                    // rows above the text: row and offset start at zero when dy reaches 0
                    qrow_next  = '0;
                    rrow_next  = '0;
                    state_next = stfr_pkg::ST_RD_ROW;
                end
            end

            stfr_pkg::ST_RD_YW:
            begin
                if (div_rsp.done)
                begin
                    qrow_next  = div_rsp.quot[5:0];
                    rrow_next  = div_rsp.rem[4:0];
                    state_next = stfr_pkg::ST_RD_ROW;
                end
            end

            stfr_pkg::ST_RD_ROW:
            begin
                byte_next[bit_reg] = hit;
                dy_next = dy_reg + 10'sd1;
                if (!dy_reg[9])
                begin
                    if ((rrow_reg + 5'd1) == scale_reg)
                    begin
                        qrow_next = qrow_reg + 6'd1;
                        rrow_next = '0;
                    end
                    else
                    begin
                        rrow_next = rrow_reg + 5'd1;
                    end
                end
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    state_next = stfr_pkg::ST_EMIT;
                end
            end

            stfr_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    state_next     = stfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stfr_pkg::ST_IDLE;
            length_reg    <= '0;
            fsp_reg       <= '0;
            fsp_valid_reg <= 1'b0;
            scale_reg     <= '0;
            stacked_reg   <= 1'b0;
            xo0_reg       <= '0;
            xo1_reg       <= '0;
            yo_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            fsp_reg       <= fsp_next;
            fsp_valid_reg <= fsp_valid_next;
            scale_reg     <= scale_next;
            stacked_reg   <= stacked_next;
            xo0_reg       <= xo0_next;
            xo1_reg       <= xo1_next;
            yo_reg        <= yo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        single_reg   <= single_next;
        prod_reg     <= prod_next;
        glyph0_reg   <= glyph0_next;
        glyph1_reg   <= glyph1_next;
        col_reg      <= col_next;
        col_ok_reg   <= col_ok_next;
        addr_reg     <= addr_next;
        dy_reg       <= dy_next;
        qrow_reg     <= qrow_next;
        rrow_reg     <= rrow_next;
        bit_reg      <= bit_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
    end

    // text store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[length_reg[ADDR_W-1:0]] <= q_cmd.char_code;
        end
        rd_data_reg <= text_mem[addr_reg];
    end

endmodule

>>> sv/scaled_text_frame_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_text_frame_renderer
// Character generator: keeps a short text and returns scaled, centered
// page-organized frame bytes of it drawn in a 5x7 font.
// ----------------------------------------------------------------------------
//  channel  dir  beat carries                         
//  req      in   action, char_code, column, page      
//  rsp      out  pixel_byte (one per read beat)       
//
//  Commands run one at a time from a two-entry queue behind req.
//  A read uses up to three passes of the ten-step divider (column of each
//  line, row offset), two text store fetches and eight row steps.
//  An append uses up to two divider passes plus centering.
//  Reset empties the text; the store itself is not cleared.
//  req stalls only while the queue is full; rsp holds its byte until taken.
// ----------------------------------------------------------------------------
module scaled_text_frame_renderer #(
    parameter int PANEL_WIDTH  = stfr_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = stfr_pkg::DEF_PANEL_HEIGHT,
    parameter int TEXT_MAX     = stfr_pkg::DEF_TEXT_MAX
) (
    input  logic        clk,
    input  logic        rst_n,
    stfr_req_if.sink    req,
    stfr_rsp_if.source  rsp
);

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    stfr_pkg::cmd_t      push_cmd;
    stfr_pkg::cmd_t      head_cmd;
    stfr_pkg::div_req_t  div_req;
    stfr_pkg::div_rsp_t  div_rsp;

    stfr_front u_front (
        .req  (req),
        .full (q_full),
        .push (q_push),
        .cmd  (push_cmd)
    );

    stfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (head_cmd)
    );

    stfr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    stfr_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .TEXT_MAX     (TEXT_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .rsp     (rsp)
    );

endmodule
